### hw/rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/ltm_pkg.sv
package ltm_pkg;
	localparam int LockEntriesDef = 64;
	localparam int WaiterEntriesDef = 32;
	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;
	typedef enum logic [2:0] {
		RC_GRANTED = 3'd0,
		RC_RELEASE_OK = 3'd1,
		RC_UNKNOWN = 3'd2,
		RC_LOCK_FULL = 3'd3,
		RC_WAIT_FULL = 3'd4
	} result_code_t;
	typedef struct packed {
		logic        req_type;
		logic [15:0] client_id;
		logic [31:0] lock_id;
	} req_t;
endpackage

### hw/rtl/lock_table_manager.sv
// The first result beat follows the serial lock-table and waiter scans; a hand-off adds a
// second beat in the cycle after the first.
// Throughput: one request at a time in the back end, set by the serial
// lock-table and waiter scans; a two-entry queue buffers new requests.
// Reset (arst_n low) clears all lock and waiter state at once; no sweep.
// Results are one-cycle strobes; the receiver cannot stall.
module lock_table_manager import ltm_pkg::*; #(
	parameter int LOCK_ENTRIES = LockEntriesDef,
	parameter int WAITER_ENTRIES = WaiterEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic req_type,
	input  logic [15:0] client_id,
	input  logic [31:0] lock_id,
	output logic strobe,
	output logic [2:0] result_code,
	output logic [15:0] dest_client,
	output logic [31:0] result_lock,
	output logic last
);
	logic q_full, q_empty, push, pop;
	req_t push_data, head;
	ltm_front u_front (.clk, .arst_n, .start, .req_type, .client_id, .lock_id,
		.q_full, .busy, .push, .push_data);
	ltm_queue u_queue (.clk, .arst_n, .push, .push_data, .pop, .empty(q_empty),
		.full(q_full), .head);
	ltm_back #(.LOCK_ENTRIES(LOCK_ENTRIES), .WAITER_ENTRIES(WAITER_ENTRIES)) u_back (
		.clk, .arst_n, .q_empty, .q_head(head), .q_pop(pop), .strobe,
		.result_code, .dest_client, .result_lock, .last);
endmodule

### hw/rtl/ltm_front.sv
module ltm_front import ltm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic req_type,
	input  logic [15:0] client_id,
	input  logic [31:0] lock_id,
	input  logic q_full,
	output logic busy,
	output logic push,
	output req_t push_data
);
	// two-entry queue depth means front stalls only on full
	assign busy = q_full;
	assign push = start && !q_full;
	assign push_data = '{req_type: req_type, client_id: client_id, lock_id: lock_id};
endmodule

### hw/rtl/ltm_queue.sv
`include "assert_macros.svh"
module ltm_queue import ltm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_data,
	input  logic pop,
	output logic empty,
	output logic full,
	output req_t head
);
	req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign empty = cnt_q == 2'd0;
	assign full = cnt_q == 2'd2;
	assign head = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, !full || pop)
	`ASSERT_IMPLIES(a_no_underflow, clk, arst_n, pop, !empty)
	`ASSERT_IMPLIES(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
endmodule

### hw/rtl/ltm_back.sv
`include "assert_macros.svh"
module ltm_back import ltm_pkg::*; #(
	parameter int LOCK_ENTRIES = LockEntriesDef,
	parameter int WAITER_ENTRIES = WaiterEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  req_t q_head,
	output logic q_pop,
	output logic strobe,
	output logic [2:0] result_code,
	output logic [15:0] dest_client,
	output logic [31:0] result_lock,
	output logic last
);
	localparam int LW = $clog2(LOCK_ENTRIES);
	localparam int WW = (WAITER_ENTRIES > 1) ? $clog2(WAITER_ENTRIES) : 1;
	localparam int LC = $clog2(LOCK_ENTRIES + 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WSCAN, S_DO, S_HAND} state_t;
	state_t state_q;

	logic [31:0] lock_ids_q [LOCK_ENTRIES];
	logic [LOCK_ENTRIES-1:0] lock_held_q;
	logic [LC-1:0] lock_cnt_q;
	logic [15:0] w_client_q [WAITER_ENTRIES];
	logic [LW-1:0] w_slot_q [WAITER_ENTRIES];
	logic [15:0] w_age_q [WAITER_ENTRIES];
	logic [WAITER_ENTRIES-1:0] w_valid_q;
	logic [15:0] arrival_q;

	req_t req_q;
	logic [LC-1:0] li_q;
	logic [31:0] rd_id_q;
	logic found_q;
	logic [LW-1:0] slot_q;
	logic [WW:0] wi_q;
	logic best_ok_q, free_ok_q;
	logic [WW-1:0] best_q, free_q;
	logic [15:0] best_d_q;
	logic [15:0] hand_client_q;
	logic rd_v_q;

	logic [WW-1:0] wi_idx;
	logic [15:0] wd;
	assign wi_idx = wi_q[WW-1:0];
	assign wd = arrival_q - w_age_q[wi_idx];

	always_ff @(posedge clk) begin
		rd_id_q <= lock_ids_q[li_q[LW-1:0]];
		if (state_q == S_DO && req_q.req_type == REQ_ACQUIRE && !found_q
				&& lock_cnt_q != LC'(LOCK_ENTRIES))
			lock_ids_q[lock_cnt_q[LW-1:0]] <= req_q.lock_id;
		if (state_q == S_DO && req_q.req_type == REQ_ACQUIRE && found_q
				&& lock_held_q[slot_q] && free_ok_q) begin
			w_client_q[free_q] <= req_q.client_id;
			w_slot_q[free_q] <= slot_q;
			w_age_q[free_q] <= arrival_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; lock_held_q <= '0; lock_cnt_q <= '0;
			w_valid_q <= '0; arrival_q <= '0; strobe <= 1'b0; q_pop <= 1'b0;
			li_q <= '0; found_q <= 1'b0; slot_q <= '0; wi_q <= '0;
			best_ok_q <= 1'b0; free_ok_q <= 1'b0; best_q <= '0; free_q <= '0;
			best_d_q <= '0; rd_v_q <= 1'b0; req_q <= '0; hand_client_q <= '0;
			result_code <= '0; dest_client <= '0; result_lock <= '0; last <= 1'b0;
		end else begin
			strobe <= 1'b0;
			q_pop <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty && !q_pop) begin
						req_q <= q_head; q_pop <= 1'b1;
						li_q <= '0; rd_v_q <= 1'b0; found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// pipelined table read: rd_id_q holds entry li_q-1
					if (rd_v_q && !found_q && rd_id_q == req_q.lock_id) begin
						found_q <= 1'b1;
						slot_q <= LW'(li_q - LC'(1));
					end
					if (li_q < lock_cnt_q && !found_q) begin
						li_q <= li_q + LC'(1); rd_v_q <= 1'b1;
					end else if (!rd_v_q || found_q || rd_id_q != req_q.lock_id
							|| li_q >= lock_cnt_q) begin
						if (!rd_v_q || li_q >= lock_cnt_q || found_q
								|| rd_id_q == req_q.lock_id) begin
							rd_v_q <= 1'b0;
							wi_q <= '0; best_ok_q <= 1'b0; free_ok_q <= 1'b0;
							state_q <= (rd_v_q && !found_q && rd_id_q != req_q.lock_id)
								? S_SCAN : S_WSCAN;
						end
					end
				end
				S_WSCAN: begin
					if (wi_q == (WW+1)'(WAITER_ENTRIES)) state_q <= S_DO;
					else begin
						if (w_valid_q[wi_idx] && w_slot_q[wi_idx] == slot_q
								&& (!best_ok_q || wd > best_d_q)) begin
							best_ok_q <= 1'b1; best_q <= wi_idx; best_d_q <= wd;
						end
						if (!w_valid_q[wi_idx] && !free_ok_q) begin
							free_ok_q <= 1'b1; free_q <= wi_idx;
						end
						wi_q <= wi_q + (WW+1)'(1);
					end
				end
				S_DO: begin
					state_q <= S_IDLE;
					result_lock <= req_q.lock_id;
					dest_client <= req_q.client_id;
					last <= 1'b1;
					strobe <= 1'b1;
					if (req_q.req_type == REQ_ACQUIRE) begin
						if (!found_q) begin
							if (lock_cnt_q == LC'(LOCK_ENTRIES)) result_code <= RC_LOCK_FULL;
							else begin
								result_code <= RC_GRANTED;
								lock_held_q[lock_cnt_q[LW-1:0]] <= 1'b1;
								lock_cnt_q <= lock_cnt_q + LC'(1);
							end
						end else if (!lock_held_q[slot_q]) begin
							result_code <= RC_GRANTED; lock_held_q[slot_q] <= 1'b1;
						end else if (!free_ok_q) result_code <= RC_WAIT_FULL;
						else begin
							strobe <= 1'b0;
							w_valid_q[free_q] <= 1'b1;
							arrival_q <= arrival_q + 16'd1;
						end
					end else if (!found_q) result_code <= RC_UNKNOWN;
					else begin
						result_code <= RC_RELEASE_OK;
						if (!best_ok_q) lock_held_q[slot_q] <= 1'b0;
						else begin
							last <= 1'b0;
							w_valid_q[best_q] <= 1'b0;
							hand_client_q <= w_client_q[best_q];
							state_q <= S_HAND;
						end
					end
				end
				S_HAND: begin
					strobe <= 1'b1; result_code <= RC_GRANTED;
					dest_client <= hand_client_q; last <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
	`ASSERT_NEXT(a_hand_follows, clk, arst_n, state_q == S_HAND, strobe && last)
	`ASSERT_IMPLIES(a_cnt_bound, clk, arst_n, 1'b1, lock_cnt_q <= LC'(LOCK_ENTRIES))
	`ASSERT_IMPLIES(a_pop_idle, clk, arst_n, q_pop, state_q == S_SCAN)
endmodule
